@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the setpoint profiler checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TSP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/tsp_pkg.sv @@
// ----------------------------------------------------------------------------
// tsp_pkg
// Types, constants and helpers for the trapezoidal setpoint profiler.
// ----------------------------------------------------------------------------
`default_nettype none

package tsp_pkg;

    localparam int NUM_AXES = 3;

    localparam logic [32:0] TOL_POS  = 33'd66;
    localparam logic [31:0] SNAP_VEL = 32'd6554;

    localparam logic [30:0] CRUISE_RESET = 31'd4588;
    localparam logic [30:0] SPEED_RESET  = 31'd9175;
    localparam logic [15:0] RATE_RESET   = 16'd20;

    localparam logic [1:0] REG_CRUISE_ACCEL = 2'd0;
    localparam logic [1:0] REG_MAX_SPEED    = 2'd1;
    localparam logic [1:0] REG_TICK_RATE    = 2'd2;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ERR,
        OP_MUL,
        OP_DECIDE,
        OP_DIV_BRK,
        OP_SET_BRK,
        OP_DIV_VEL,
        OP_SET_VEL,
        OP_DIV_POS,
        OP_SET_POS,
        OP_SNAP,
        OP_OUT
    } tsp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_MUL,
        S_CHOOSE,
        S_BRK_GO,
        S_BRK_WAIT,
        S_BRK_SET,
        S_VEL_GO,
        S_VEL_WAIT,
        S_VEL_SET,
        S_POS_GO,
        S_POS_WAIT,
        S_POS_SET,
        S_SNAP,
        S_NEXT,
        S_OUT
    } tsp_state_t;

    typedef struct packed {
        tsp_op_t    op;
        logic [1:0] axis;
    } tsp_cmd_t;

    typedef struct packed {
        logic tol;
        logic snap;
        logic brake;
        logic div_done;
    } tsp_status_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
        logic signed [31:0] acc_z;
        logic [2:0]         done_mask;
    } tsp_result_t;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
        logic signed [31:0] r;
        if (x > 34'sh0_7FFF_FFFF)
        begin
            r = S32_MAX;
        end
        else if (x < -34'sh0_8000_0000)
        begin
            r = S32_MIN;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tsp_if.sv @@
// ----------------------------------------------------------------------------
// tsp_in_if / tsp_out_if
// Valid/ready channels carrying targets in and profiled setpoints out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsp_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;

    modport source (output valid, output target_x, output target_y, output target_z,
                    input ready);
    modport sink   (input valid, input target_x, input target_y, input target_z,
                    output ready);
endinterface

interface tsp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic [2:0]         done_mask;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output vel_x, output vel_y, output vel_z,
                    output acc_x, output acc_y, output acc_z,
                    output done_mask, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input vel_x, input vel_y, input vel_z,
                    input acc_x, input acc_y, input acc_z,
                    input done_mask, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/trapezoid_setpoint_profiler.sv @@
// ----------------------------------------------------------------------------
// trapezoid_setpoint_profiler
// Three-axis trapezoidal velocity profile generator, Q15.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one control tick (target_x/y/z); out_ch returns one item per
//   tick with position, velocity, acceleration and done_mask after the tick.
//   Registers cruise_accel, max_speed, tick_rate are written through cfg_we,
//   cfg_index and cfg_data; the user must write them only while the block is
//   idle, which the block itself does not enforce. Axes are processed one
//   after another. An axis within tolerance snaps to its target when slow
//   enough; one that moves uses the single shared 64-step divider for the
//   braking quotient when it brakes, then for a/tick_rate and v/tick_rate.
//   The result sits in an output register: the block takes the next tick
//   while it waits, and only holds at the end of that tick's work if the
//   receiver still stalls the previous result.
//   Reset clears position, velocity and acceleration of every axis and the
//   done bits and loads the register defaults; no item is held across reset.
// ----------------------------------------------------------------------------
`default_nettype none

module trapezoid_setpoint_profiler
    import tsp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    tsp_in_if.sink           in_ch,
    tsp_out_if.source        out_ch,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [30:0] cfg_data
);

    tsp_cmd_t    cmd;
    tsp_status_t status;
    tsp_result_t result;

    tsp_controller u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    tsp_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .target_x  (in_ch.target_x),
        .target_y  (in_ch.target_y),
        .target_z  (in_ch.target_z),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

    assign out_ch.pos_x     = result.pos_x;
    assign out_ch.pos_y     = result.pos_y;
    assign out_ch.pos_z     = result.pos_z;
    assign out_ch.vel_x     = result.vel_x;
    assign out_ch.vel_y     = result.vel_y;
    assign out_ch.vel_z     = result.vel_z;
    assign out_ch.acc_x     = result.acc_x;
    assign out_ch.acc_y     = result.acc_y;
    assign out_ch.acc_z     = result.acc_z;
    assign out_ch.done_mask = result.done_mask;

endmodule

`default_nettype wire

@@ hw/rtl/tsp_divider.sv @@
// ----------------------------------------------------------------------------
// tsp_divider
// Unsigned restoring divider, 64-bit dividend, 34-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tsp_divider
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [33:0] divisor,
    output logic             done,
    output logic [63:0]      quotient
);

    logic [63:0] quo_reg, quo_next;
    logic [34:0] rem_reg, rem_next;
    logic [33:0] dsr_reg, dsr_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [34:0] shifted;
    logic        ge;

    always_comb
    begin
        shifted   = {rem_reg[33:0], quo_reg[63]};
        ge        = (shifted >= {1'b0, dsr_reg});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (shifted - {1'b0, dsr_reg}) : shifted;
            quo_next = {quo_reg[62:0], ge};
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

@@ hw/rtl/tsp_datapath.sv @@
// ----------------------------------------------------------------------------
// tsp_datapath
// Axis state, configuration registers, arithmetic and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tsp_datapath
    import tsp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tsp_cmd_t           cmd,
    output tsp_status_t             status,
    input  wire logic signed [31:0] target_x,
    input  wire logic signed [31:0] target_y,
    input  wire logic signed [31:0] target_z,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [30:0]        cfg_data,
    output tsp_result_t             result
);

    logic [30:0] cruise_reg;
    logic [30:0] speed_reg;
    logic [15:0] rate_reg;

    logic signed [31:0] tgt_reg [NUM_AXES];
    logic signed [31:0] pos_reg [NUM_AXES];
    logic signed [31:0] vel_reg [NUM_AXES];
    logic signed [31:0] acc_reg [NUM_AXES];
    logic [2:0]         arrived_reg;

    logic signed [32:0] err_reg;
    logic [32:0]        aerr_reg;
    logic [31:0]        avel_reg;
    logic [63:0]        v2_reg;
    logic [63:0]        stop_reg;
    tsp_result_t        result_reg;

    logic [1:0]         k;
    logic signed [32:0] err_c;
    logic [32:0]        aerr_c;
    logic [31:0]        mag_in;
    logic [63:0]        prod_lo;
    logic [63:0]        stop_sum;
    logic [63:0]        stop_c;
    logic               err_pos;
    logic [63:0]        div_dividend;
    logic [33:0]        div_divisor;
    logic               div_start;
    logic               div_done;
    logic [63:0]        div_quo;
    logic [15:0]        rate_eff;
    logic [31:0]        q32;
    logic signed [33:0] qs;
    logic signed [31:0] acc_brk;
    logic signed [31:0] acc_dec;
    logic signed [31:0] cur_acc;
    logic signed [31:0] cur_vel;

    assign k        = cmd.axis;
    assign cur_acc  = acc_reg[k];
    assign cur_vel  = vel_reg[k];
    assign err_c    = {tgt_reg[k][31], tgt_reg[k]} - {pos_reg[k][31], pos_reg[k]};
    assign aerr_c   = err_c[32] ? (33'd0 - err_c) : err_c;
    assign mag_in   = vel_reg[k][31] ? (32'd0 - vel_reg[k]) : vel_reg[k];
    assign prod_lo  = {33'd0, cruise_reg} * {32'd0, aerr_reg[31:0]};
    assign stop_sum = prod_lo + (aerr_reg[32] ? {1'b0, cruise_reg, 32'd0} : 64'd0);
    assign stop_c   = {stop_sum[62:0], 1'b0};
    assign err_pos  = !err_reg[32] && (err_reg != 33'sd0);
    assign rate_eff = (rate_reg == 16'd0) ? 16'd1 : rate_reg;
    assign q32      = div_quo[31:0];

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = {18'd0, rate_eff};
        case (cmd.op)
            OP_DIV_BRK:
            begin
                div_start    = 1'b1;
                div_dividend = v2_reg;
                div_divisor  = {aerr_reg, 1'b0};
            end
            OP_DIV_VEL:
            begin
                div_start    = 1'b1;
                div_dividend = {32'd0, cur_acc[31] ? (32'd0 - cur_acc) : cur_acc};
            end
            OP_DIV_POS:
            begin
                div_start    = 1'b1;
                div_dividend = {32'd0, cur_vel[31] ? (32'd0 - cur_vel) : cur_vel};
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    tsp_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        if (err_pos)
        begin
            acc_brk = (div_quo > 64'h8000_0000) ? S32_MIN : (32'd0 - div_quo[31:0]);
        end
        else
        begin
            acc_brk = (div_quo > 64'h7FFF_FFFF) ? S32_MAX : div_quo[31:0];
        end
        if (avel_reg > {1'b0, speed_reg})
        begin
            acc_dec = '0;
        end
        else
        begin
            acc_dec = err_pos ? $signed({1'b0, cruise_reg}) : -$signed({1'b0, cruise_reg});
        end
    end

    always_comb
    begin
        if (cmd.op == OP_SET_VEL)
        begin
            qs = cur_acc[31] ? -$signed({2'b00, q32}) : $signed({2'b00, q32});
        end
        else
        begin
            qs = cur_vel[31] ? -$signed({2'b00, q32}) : $signed({2'b00, q32});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cruise_reg  <= CRUISE_RESET;
            speed_reg   <= SPEED_RESET;
            rate_reg    <= RATE_RESET;
            arrived_reg <= '0;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CRUISE_ACCEL: cruise_reg <= cfg_data;
                    REG_MAX_SPEED:    speed_reg  <= cfg_data;
                    REG_TICK_RATE:    rate_reg   <= cfg_data[15:0];
                    default:          ;
                endcase
            end
            case (cmd.op)
                OP_MUL:
                begin
                    arrived_reg[k] <= 1'b0;
                end
                OP_DECIDE:
                begin
                    acc_reg[k] <= acc_dec;
                end
                OP_SET_BRK:
                begin
                    acc_reg[k] <= acc_brk;
                end
                OP_SET_VEL:
                begin
                    vel_reg[k] <= sat32({{2{cur_vel[31]}}, cur_vel} + qs);
                end
                OP_SET_POS:
                begin
                    pos_reg[k] <= sat32({{2{pos_reg[k][31]}}, pos_reg[k]} + qs);
                end
                OP_SNAP:
                begin
                    pos_reg[k]     <= tgt_reg[k];
                    vel_reg[k]     <= '0;
                    acc_reg[k]     <= '0;
                    arrived_reg[k] <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                tgt_reg[0] <= target_x;
                tgt_reg[1] <= target_y;
                tgt_reg[2] <= target_z;
            end
            OP_ERR:
            begin
                err_reg  <= err_c;
                aerr_reg <= aerr_c;
                avel_reg <= mag_in;
            end
            OP_MUL:
            begin
                v2_reg   <= avel_reg * avel_reg;
                stop_reg <= stop_c;
            end
            OP_OUT:
            begin
                result_reg.pos_x     <= pos_reg[0];
                result_reg.pos_y     <= pos_reg[1];
                result_reg.pos_z     <= pos_reg[2];
                result_reg.vel_x     <= vel_reg[0];
                result_reg.vel_y     <= vel_reg[1];
                result_reg.vel_z     <= vel_reg[2];
                result_reg.acc_x     <= acc_reg[0];
                result_reg.acc_y     <= acc_reg[1];
                result_reg.acc_z     <= acc_reg[2];
                result_reg.done_mask <= arrived_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign status.tol      = (aerr_c >= TOL_POS);
    assign status.snap     = (mag_in < SNAP_VEL);
    assign status.brake    = (v2_reg >= stop_reg);
    assign status.div_done = div_done;
    assign result          = result_reg;

endmodule

`default_nettype wire

@@ hw/rtl/tsp_controller.sv @@
// ----------------------------------------------------------------------------
// tsp_controller
// Steps each axis through error, then a snap or the decision and divisions.
// ----------------------------------------------------------------------------
`default_nettype none

module tsp_controller
    import tsp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire tsp_status_t status,
    output tsp_cmd_t         cmd
);

    tsp_state_t state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic       oval_reg, oval_next;
    logic       out_free;

    assign out_free = !oval_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_ERR;
                    axis_next  = 2'd0;
                end
            end
            S_ERR:
            begin
                if (status.tol)
                begin
                    state_next = S_MUL;
                end
                else if (status.snap)
                begin
                    state_next = S_SNAP;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_MUL:      state_next = S_CHOOSE;
            S_CHOOSE:   state_next = status.brake ? S_BRK_GO : S_VEL_GO;
            S_BRK_GO:   state_next = S_BRK_WAIT;
            S_BRK_WAIT: state_next = status.div_done ? S_BRK_SET : S_BRK_WAIT;
            S_BRK_SET:  state_next = S_VEL_GO;
            S_VEL_GO:   state_next = S_VEL_WAIT;
            S_VEL_WAIT: state_next = status.div_done ? S_VEL_SET : S_VEL_WAIT;
            S_VEL_SET:  state_next = S_POS_GO;
            S_POS_GO:   state_next = S_POS_WAIT;
            S_POS_WAIT: state_next = status.div_done ? S_POS_SET : S_POS_WAIT;
            S_POS_SET:  state_next = S_NEXT;
            S_SNAP:     state_next = S_NEXT;
            S_NEXT:
            begin
                if (axis_reg == 2'd2)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_ERR;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.axis = axis_reg;
        cmd.op   = OP_NONE;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.op   = in_valid ? OP_LOAD : OP_NONE;
            end
            S_ERR:      cmd.op = OP_ERR;
            S_MUL:      cmd.op = OP_MUL;
            S_CHOOSE:   cmd.op = status.brake ? OP_NONE : OP_DECIDE;
            S_BRK_GO:   cmd.op = OP_DIV_BRK;
            S_BRK_SET:  cmd.op = OP_SET_BRK;
            S_VEL_GO:   cmd.op = OP_DIV_VEL;
            S_VEL_SET:  cmd.op = OP_SET_VEL;
            S_POS_GO:   cmd.op = OP_DIV_POS;
            S_POS_SET:  cmd.op = OP_SET_POS;
            S_SNAP:     cmd.op = OP_SNAP;
            S_OUT:      cmd.op = out_free ? OP_OUT : OP_NONE;
            default:    cmd.op = OP_NONE;
        endcase
    end

    always_comb
    begin
        oval_next = oval_reg;
        if (oval_reg && out_ready)
        begin
            oval_next = 1'b0;
        end
        if (state_reg == S_OUT && out_free)
        begin
            oval_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= 2'd0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            oval_reg  <= oval_next;
        end
    end

    assign out_valid = oval_reg;

endmodule

`default_nettype wire

@@ hw/rtl/tsp_checker.sv @@
// ----------------------------------------------------------------------------
// tsp_checker
// Port-level checks for the setpoint profiler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tsp_checker
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [31:0] pos_x,
    input wire logic signed [31:0] vel_x,
    input wire logic signed [31:0] vel_y,
    input wire logic signed [31:0] vel_z,
    input wire logic signed [31:0] acc_x,
    input wire logic [2:0]         done_mask
);

    // one tick at a time
    `TSP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

    // a done axis has been snapped and stands still
    `TSP_ASSERT_NOW(a_done_x_still, out_valid && done_mask[0], vel_x == 0 && acc_x == 0, "x moving")
    `TSP_ASSERT_NOW(a_done_yz_still, out_valid && done_mask[1] && done_mask[2],
                    vel_y == 0 && vel_z == 0, "y or z moving")

    // stalled item holds
    `TSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pos_x), "item dropped")

endmodule

bind trapezoid_setpoint_profiler tsp_checker u_tsp_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .pos_x     (out_ch.pos_x),
    .vel_x     (out_ch.vel_x),
    .vel_y     (out_ch.vel_y),
    .vel_z     (out_ch.vel_z),
    .acc_x     (out_ch.acc_x),
    .done_mask (out_ch.done_mask)
);

`default_nettype wire

@@ bench/trapezoid_setpoint_profiler_tb.sv @@
// ----------------------------------------------------------------------------
// trapezoid_setpoint_profiler_tb
// Self-checking bench: a directed table of targets and register writes, then
// random target sequences held for random runs of ticks. Each result item is
// checked against a cycle-free profile predictor or a directed expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module trapezoid_setpoint_profiler_tb;
    import tsp_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;

    typedef enum logic [1:0] { ROW_TICK, ROW_FOLLOW, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [1:0]         idx;
        logic [30:0]        data;
        logic signed [31:0] tgt [3];
        bit                 typed;
        tsp_result_t        want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [30:0] cfg_data;

    tsp_in_if  in_ch ();
    tsp_out_if out_ch ();

    trapezoid_setpoint_profiler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    longint      axis_pos [3];
    longint      axis_vel [3];
    longint      axis_acc [3];
    logic [2:0]  arrived;
    longint unsigned cruise;
    longint unsigned speed_cap;
    longint unsigned rate_reg;

    tsp_result_t setpoint_q [$];
    row_t        rows [$];
    int          idle_pct;
    int          stall_pct;
    int          quiet_cycles;
    bit          failed;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint clamp_s32(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic void profile_axis(int k, longint tgt);
        longint          err;
        longint unsigned aerr;
        longint unsigned avel;
        longint unsigned v2;
        longint unsigned stop_dist;
        longint unsigned m;
        longint          rate;
        longint          acc;
        err  = tgt - axis_pos[k];
        aerr = err < 0 ? -err : err;
        avel = axis_vel[k] < 0 ? -axis_vel[k] : axis_vel[k];
        rate = rate_reg == 0 ? 1 : rate_reg;
        if (aerr >= 66)
        begin
            v2 = avel * avel;
            stop_dist = 2 * cruise * aerr;
            arrived[k] = 1'b0;
            if (v2 >= stop_dist)
            begin
                m = v2 / (2 * aerr);
                if (err > 0)
                    acc = (m > 64'd2147483648) ? -64'sd2147483648 : -longint'(m);
                else
                    acc = (m > 64'd2147483647) ? 64'sd2147483647 : longint'(m);
            end
            else if (avel > speed_cap)
                acc = 0;
            else
                acc = err > 0 ? longint'(cruise) : -longint'(cruise);
            axis_acc[k] = acc;
            axis_vel[k] = clamp_s32(axis_vel[k] + acc / rate);
            axis_pos[k] = clamp_s32(axis_pos[k] + axis_vel[k] / rate);
        end
        else if (avel < 6554)
        begin
            axis_pos[k] = tgt;
            axis_vel[k] = 0;
            axis_acc[k] = 0;
            arrived[k] = 1'b1;
        end
    endfunction

    function automatic tsp_result_t profile_tick(logic signed [31:0] t [3]);
        tsp_result_t r;
        for (int k = 0; k < 3; k++)
            profile_axis(k, longint'(t[k]));
        r.pos_x = axis_pos[0][31:0];
        r.pos_y = axis_pos[1][31:0];
        r.pos_z = axis_pos[2][31:0];
        r.vel_x = axis_vel[0][31:0];
        r.vel_y = axis_vel[1][31:0];
        r.vel_z = axis_vel[2][31:0];
        r.acc_x = axis_acc[0][31:0];
        r.acc_y = axis_acc[1][31:0];
        r.acc_z = axis_acc[2][31:0];
        r.done_mask = arrived;
        return r;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [30:0] data);
        in_ch.valid <= 1'b0;
        wait (setpoint_q.size() == 0);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_CRUISE_ACCEL: cruise = data;
            REG_MAX_SPEED:    speed_cap = data;
            REG_TICK_RATE:    rate_reg = data[15:0];
            default: ;
        endcase
    endtask

    task automatic send_tick(logic signed [31:0] t [3], bit typed, tsp_result_t want);
        tsp_result_t e;
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.target_x <= t[0];
        in_ch.target_y <= t[1];
        in_ch.target_z <= t[2];
        do
            @(posedge clk);
        while (!in_ch.ready);
        e = profile_tick(t);
        setpoint_q.push_back(typed ? want : e);
        @(negedge clk);
    endtask

    task automatic add_tick(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z);
        row_t r;
        r.kind = ROW_TICK;
        r.tgt[0] = x;
        r.tgt[1] = y;
        r.tgt[2] = z;
        r.typed = 1'b0;
        r.want = '0;
        rows.push_back(r);
    endtask

    task automatic add_row(row_kind_t kind, logic [1:0] idx, logic [30:0] data);
        row_t r;
        r.kind = kind;
        r.idx = idx;
        r.data = data;
        r.typed = 1'b0;
        r.want = '0;
        rows.push_back(r);
    endtask

    function automatic logic signed [31:0] near_target(int k);
        int span;
        if ($urandom_range(9) == 0)
            return $urandom;
        span = 1 << $urandom_range(6, 22);
        return 32'(clamp_s32(axis_pos[k] + $signed($urandom_range(2 * span)) - span));
    endfunction

    task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a)
        begin
            $error("%s: expected %0h, got %0h", name, e, a);
            failed = 1'b1;
        end
    endtask

    always @(posedge clk)
    begin
        tsp_result_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (setpoint_q.size() == 0)
            begin
                $error("result item with no tick outstanding");
                failed = 1'b1;
            end
            else
            begin
                e = setpoint_q.pop_front();
                check_field("pos_x", e.pos_x, out_ch.pos_x);
                check_field("pos_y", e.pos_y, out_ch.pos_y);
                check_field("pos_z", e.pos_z, out_ch.pos_z);
                check_field("vel_x", e.vel_x, out_ch.vel_x);
                check_field("vel_y", e.vel_y, out_ch.vel_y);
                check_field("vel_z", e.vel_z, out_ch.vel_z);
                check_field("acc_x", e.acc_x, out_ch.acc_x);
                check_field("acc_y", e.acc_y, out_ch.acc_y);
                check_field("acc_z", e.acc_z, out_ch.acc_z);
                check_field("done_mask", e.done_mask, out_ch.done_mask);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("trapezoid_setpoint_profiler regression: fail");
            $finish;
        end
    end

    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= stall_pct);

    initial
    begin
        logic signed [31:0] t [3];
        tsp_result_t        none;
        int                 hold;
        int                 pause_at;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.target_x = '0;
        in_ch.target_y = '0;
        in_ch.target_z = '0;
        out_ch.ready = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        quiet_cycles = 0;
        failed       = 1'b0;
        none         = '0;
        cruise       = CRUISE_RESET;
        speed_cap    = SPEED_RESET;
        rate_reg     = RATE_RESET;
        arrived      = '0;
        for (int k = 0; k < 3; k++)
        begin
            axis_pos[k] = 0;
            axis_vel[k] = 0;
            axis_acc[k] = 0;
        end
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        add_tick(0, 0, 0);
        rows[$].typed = 1'b1;
        rows[$].want.done_mask = 3'b111;
        add_tick(S32_MAX, 0, 0);
        rows[$].typed = 1'b1;
        rows[$].want.pos_x = 11;
        rows[$].want.vel_x = 229;
        rows[$].want.acc_x = 4588;
        rows[$].want.done_mask = 3'b110;
        add_tick(S32_MIN, S32_MIN, S32_MAX);
        add_tick(S32_MAX, S32_MAX, S32_MIN);
        add_tick(65, -65, 66);
        add_row(ROW_CFG, REG_TICK_RATE, 31'd0);
        add_tick(1000, -1000, 5000000);
        add_tick(1000, -1000, 5000000);
        add_row(ROW_CFG, REG_CRUISE_ACCEL, 31'd0);
        add_tick(-70000, 70000, 0);
        add_tick(-70000, 70000, 0);
        add_row(ROW_CFG, REG_CRUISE_ACCEL, 31'h7FFF_FFFF);
        add_row(ROW_CFG, REG_MAX_SPEED, 31'd0);
        add_tick(S32_MIN, S32_MAX, 123456);
        add_tick(0, 0, 0);
        add_row(ROW_CFG, REG_CRUISE_ACCEL, 31'd100000);
        add_row(ROW_CFG, REG_MAX_SPEED, 31'h7FFF_FFFF);
        add_row(ROW_CFG, REG_TICK_RATE, 31'd1);
        add_tick(40000000, -40000000, 40000000);
        add_row(ROW_FOLLOW, '0, '0);
        add_row(ROW_FOLLOW, '0, '0);
        add_row(ROW_CFG, REG_TICK_RATE, 31'd65535);
        add_tick(12345, -54321, 0);
        add_row(ROW_CFG, REG_CRUISE_ACCEL, CRUISE_RESET);
        add_row(ROW_CFG, REG_MAX_SPEED, SPEED_RESET);
        add_row(ROW_CFG, REG_TICK_RATE, RATE_RESET);

        foreach (rows[i])
        begin
            case (rows[i].kind)
                ROW_CFG:
                    write_reg(rows[i].idx, rows[i].data);
                ROW_FOLLOW:
                begin
                    for (int k = 0; k < 3; k++)
                        t[k] = axis_pos[k][31:0];
                    send_tick(t, 1'b0, none);
                end
                default:
                    send_tick(rows[i].tgt, rows[i].typed, rows[i].want);
            endcase
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 80; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 80; end
                default: begin idle_pct = 9; stall_pct = 9; end
            endcase
            case (ph)
                0: ;
                3:
                begin
                    write_reg(REG_CRUISE_ACCEL, 31'd1);
                    write_reg(REG_MAX_SPEED, 31'h7FFF_FFFF);
                    write_reg(REG_TICK_RATE, 31'd1);
                end
                5:
                begin
                    write_reg(REG_CRUISE_ACCEL, 31'h7FFF_FFFF);
                    write_reg(REG_MAX_SPEED, 31'd0);
                    write_reg(REG_TICK_RATE, 31'd65535);
                end
                default:
                begin
                    write_reg(REG_CRUISE_ACCEL, 31'($urandom_range(200000, 1)));
                    write_reg(REG_MAX_SPEED, 31'($urandom_range(500000)));
                    write_reg(REG_TICK_RATE, 31'($urandom_range(100, 1)));
                end
            endcase
            pause_at = $urandom_range(150, 20);
            for (int n = 0; n < 185;)
            begin
                for (int k = 0; k < 3; k++)
                    t[k] = near_target(k);
                hold = ($urandom_range(9) == 0) ? 1 : $urandom_range(40, 5);
                for (int h = 0; h < hold && n < 185; h++, n++)
                begin
                    if (n == pause_at)
                    begin
                        in_ch.valid <= 1'b0;
                        wait (setpoint_q.size() == 0);
                        @(negedge clk);
                    end
                    send_tick(t, 1'b0, none);
                end
            end
        end
        in_ch.valid <= 1'b0;

        wait (setpoint_q.size() == 0);
        repeat (700) @(posedge clk);
        if (!failed)
            $display("trapezoid_setpoint_profiler regression: pass");
        else
            $display("trapezoid_setpoint_profiler regression: fail");
        $finish;
    end

endmodule
